### rtl/prf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Packet ring FIFO package
// Operation codes, result kinds and default sizes shared by the block.
// ----------------------------------------------------------------------------
package prf_pkg;

    localparam logic [1:0] OP_PUSH_BYTE  = 2'd0;
    localparam logic [1:0] OP_POP        = 2'd1;
    localparam logic [1:0] OP_PUSH_EMPTY = 2'd2;

    localparam logic [1:0] KIND_ACCEPTED = 2'd0;
    localparam logic [1:0] KIND_DROPPED  = 2'd1;
    localparam logic [1:0] KIND_DATA     = 2'd2;
    localparam logic [1:0] KIND_EMPTY    = 2'd3;

    localparam int DEF_SLOT_COUNT   = 16;
    localparam int DEF_PACKET_BYTES = 32;
    localparam int CMD_QUEUE_DEPTH  = 4;

endpackage

### rtl/prf_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module prf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/prf_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Packet ring FIFO front end
// Accepts input transactions, writes packet bytes and lengths, tracks the
// ring pointers and queues one command per result run for the back end.
// ----------------------------------------------------------------------------
module prf_front
    import prf_pkg::*;
#(
    parameter int SLOT_COUNT   = DEF_SLOT_COUNT,
    parameter int PACKET_BYTES = DEF_PACKET_BYTES,
    localparam int SLOT_W = $clog2(SLOT_COUNT),
    localparam int IDX_W  = (PACKET_BYTES > 1) ? $clog2(PACKET_BYTES) : 1,
    localparam int LEN_W  = $clog2(PACKET_BYTES + 1)
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    item_valid,
    output logic                    item_ready,
    input  logic [1:0]              op,
    input  logic [7:0]              byte_value,
    input  logic                    byte_last,
    input  logic                    cmd_full,
    output logic                    cmd_push,
    output logic [SLOT_W+1:0]       cmd_data,
    input  logic                    pop_done,
    output logic                    pay_we,
    output logic [SLOT_W+IDX_W-1:0] pay_waddr,
    output logic [7:0]              pay_wdata,
    output logic                    len_we,
    output logic [SLOT_W-1:0]       len_waddr,
    output logic [LEN_W-1:0]        len_wdata
);

    logic [SLOT_W-1:0] write_slot_reg, write_slot_next;
    logic [SLOT_W-1:0] read_slot_reg, read_slot_next;
    logic [LEN_W-1:0]  taken_reg, taken_next;
    logic              open_reg, open_next;
    logic              dropping_reg, dropping_next;
    logic              pending_reg, pending_next;

    logic              accept;
    logic [SLOT_W-1:0] write_inc;
    logic [SLOT_W-1:0] read_inc;
    logic              dropping_eff;
    logic [LEN_W-1:0]  taken_eff;
    logic [LEN_W-1:0]  taken_after;
    logic              store;
    logic              close;

    assign item_ready = !cmd_full && !(op == OP_POP && pending_reg);
    assign accept     = item_valid && item_ready;

    assign write_inc = (write_slot_reg == SLOT_W'(SLOT_COUNT - 1)) ? '0
                                                                   : write_slot_reg + 1'b1;
    assign read_inc  = (read_slot_reg == SLOT_W'(SLOT_COUNT - 1)) ? '0
                                                                  : read_slot_reg + 1'b1;

    assign dropping_eff = open_reg ? dropping_reg : (write_inc == read_slot_reg);
    assign taken_eff    = open_reg ? taken_reg : '0;
    assign store        = !dropping_eff && (taken_eff < LEN_W'(PACKET_BYTES));
    assign taken_after  = taken_eff + LEN_W'(store);

    assign pay_waddr = {write_slot_reg, taken_eff[IDX_W-1:0]};
    assign pay_wdata = byte_value;
    assign len_waddr = write_slot_reg;
    assign len_wdata = (op == OP_PUSH_BYTE) ? taken_after : taken_eff;

    always_comb
    begin
        write_slot_next = write_slot_reg;
        read_slot_next  = read_slot_reg;
        taken_next      = taken_reg;
        open_next       = open_reg;
        dropping_next   = dropping_reg;
        pending_next    = pending_reg;
        cmd_push        = 1'b0;
        cmd_data        = '0;
        pay_we          = 1'b0;
        len_we          = 1'b0;
        close           = 1'b0;

        if (pop_done)
        begin
            pending_next = 1'b0;
        end

        if (accept)
        begin
            case (op)
                OP_PUSH_BYTE:
                begin
                    pay_we = store;
                    close  = byte_last;
                    if (!byte_last)
                    begin
                        open_next     = 1'b1;
                        dropping_next = dropping_eff;
                        taken_next    = taken_after;
                    end
                end
                OP_PUSH_EMPTY:
                begin
                    close = 1'b1;
                end
                OP_POP:
                begin
                    cmd_push = 1'b1;
                    if (write_slot_reg == read_slot_reg)
                    begin
                        cmd_data = {{SLOT_W{1'b0}}, KIND_EMPTY};
                    end
                    else
                    begin
                        cmd_data       = {read_slot_reg, KIND_DATA};
                        read_slot_next = read_inc;
                        pending_next   = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase

            if (close)
            begin
                cmd_push      = 1'b1;
                open_next     = 1'b0;
                dropping_next = 1'b0;
                taken_next    = '0;
                if (dropping_eff)
                begin
                    cmd_data = {{SLOT_W{1'b0}}, KIND_DROPPED};
                end
                else
                begin
                    cmd_data        = {{SLOT_W{1'b0}}, KIND_ACCEPTED};
                    len_we          = 1'b1;
                    write_slot_next = write_inc;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            write_slot_reg <= '0;
            read_slot_reg  <= '0;
            taken_reg      <= '0;
            open_reg       <= 1'b0;
            dropping_reg   <= 1'b0;
            pending_reg    <= 1'b0;
        end
        else
        begin
            write_slot_reg <= write_slot_next;
            read_slot_reg  <= read_slot_next;
            taken_reg      <= taken_next;
            open_reg       <= open_next;
            dropping_reg   <= dropping_next;
            pending_reg    <= pending_next;
        end
    end

endmodule

### rtl/prf_cmd_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Packet ring FIFO command queue
// Small first-in first-out queue of commands between front and back end.
// ----------------------------------------------------------------------------
module prf_cmd_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic             empty,
    output logic [WIDTH-1:0] head
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign head    = entry_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

### rtl/prf_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Packet ring FIFO back end
// Takes queued commands and drives the result stream, reading a popped
// packet from the payload memory one byte per cycle, with zero padding, while the receiver takes them.
// ----------------------------------------------------------------------------
module prf_back
    import prf_pkg::*;
#(
    parameter int SLOT_COUNT   = DEF_SLOT_COUNT,
    parameter int PACKET_BYTES = DEF_PACKET_BYTES,
    localparam int SLOT_W = $clog2(SLOT_COUNT),
    localparam int IDX_W  = (PACKET_BYTES > 1) ? $clog2(PACKET_BYTES) : 1,
    localparam int LEN_W  = $clog2(PACKET_BYTES + 1)
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cmd_empty,
    input  logic [SLOT_W+1:0]       cmd_head,
    output logic                    cmd_pop,
    output logic                    pop_done,
    output logic                    len_re,
    output logic [SLOT_W-1:0]       len_raddr,
    input  logic [LEN_W-1:0]        len_rdata,
    output logic                    pay_re,
    output logic [SLOT_W+IDX_W-1:0] pay_raddr,
    input  logic [7:0]              pay_rdata,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [1:0]              out_kind,
    output logic [7:0]              out_byte,
    output logic                    out_last
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_LEN    = 2'd1;
    localparam logic [1:0] ST_STREAM = 2'd2;

    logic [1:0]        state_reg, state_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [LEN_W-1:0]  idx_reg, idx_next;
    logic              rd_pend_reg, rd_pend_next;
    logic              rd_pad_reg, rd_pad_next;
    logic              rd_last_reg, rd_last_next;
    logic              valid_reg, valid_next;
    logic [1:0]        kind_reg, kind_next;
    logic [7:0]        byte_reg, byte_next;
    logic              last_reg, last_next;

    logic              out_free;
    logic [1:0]        head_kind;
    logic [SLOT_W-1:0] head_slot;
    logic              load;
    logic              issue;

    assign out_free  = !valid_reg || out_ready;
    assign head_kind = cmd_head[1:0];
    assign head_slot = cmd_head[SLOT_W+1:2];
    assign len_raddr = head_slot;
    assign pay_raddr = {slot_reg, idx_reg[IDX_W-1:0]};

    assign out_valid = valid_reg;
    assign out_kind  = kind_reg;
    assign out_byte  = byte_reg;
    assign out_last  = last_reg;

    always_comb
    begin
        state_next   = state_reg;
        slot_next    = slot_reg;
        len_next     = len_reg;
        idx_next     = idx_reg;
        rd_pend_next = rd_pend_reg;
        rd_pad_next  = rd_pad_reg;
        rd_last_next = rd_last_reg;
        valid_next   = valid_reg;
        kind_next    = kind_reg;
        byte_next    = byte_reg;
        last_next    = last_reg;
        cmd_pop      = 1'b0;
        pop_done     = 1'b0;
        len_re       = 1'b0;
        pay_re       = 1'b0;
        load         = 1'b0;
        issue        = 1'b0;

        if (valid_reg && out_ready)
        begin
            valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (!cmd_empty)
                begin
                    if (head_kind == KIND_DATA)
                    begin
                        cmd_pop    = 1'b1;
                        len_re     = 1'b1;
                        slot_next  = head_slot;
                        state_next = ST_LEN;
                    end
                    else if (out_free)
                    begin
                        cmd_pop    = 1'b1;
                        valid_next = 1'b1;
                        kind_next  = head_kind;
                        byte_next  = 8'd0;
                        last_next  = 1'b1;
                    end
                end
            end
            ST_LEN:
            begin
                len_next     = len_rdata;
                idx_next     = '0;
                rd_pend_next = 1'b0;
                state_next   = ST_STREAM;
            end
            ST_STREAM:
            begin
                load  = rd_pend_reg && out_free;
                issue = (idx_reg < LEN_W'(PACKET_BYTES)) && (!rd_pend_reg || load);
                if (load)
                begin
                    valid_next   = 1'b1;
                    kind_next    = KIND_DATA;
                    byte_next    = rd_pad_reg ? 8'd0 : pay_rdata;
                    last_next    = rd_last_reg;
                    rd_pend_next = 1'b0;
                    if (rd_last_reg)
                    begin
                        pop_done   = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
                if (issue)
                begin
                    pay_re       = 1'b1;
                    rd_pend_next = 1'b1;
                    rd_pad_next  = (idx_reg >= len_reg);
                    rd_last_next = (idx_reg == LEN_W'(PACKET_BYTES - 1));
                    idx_next     = idx_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            rd_pend_reg <= 1'b0;
            valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            rd_pend_reg <= rd_pend_next;
            valid_reg   <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg    <= slot_next;
        len_reg     <= len_next;
        idx_reg     <= idx_next;
        rd_pad_reg  <= rd_pad_next;
        rd_last_reg <= rd_last_next;
        kind_reg    <= kind_next;
        byte_reg    <= byte_next;
        last_reg    <= last_next;
    end

endmodule

### rtl/packet_ring_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Packet ring FIFO
// Ring of fixed-size packet slots with per-slot lengths and zero padding.
// ----------------------------------------------------------------------------
// The input stream carries one transaction per item: tuser selects a byte
// push, a pop or an empty packet push, tdata holds the byte and tlast ends
// the pushed packet. At most SLOT_COUNT-1 packets are held; a packet that
// finds the ring full at its first item is dropped as a whole.
// The output stream gives one accepted or dropped result when a packet ends,
// one empty result for a pop of an empty ring, or PACKET_BYTES data bytes
// with tlast on the final one.
// Pushed bytes are taken one per cycle while the command queue has room. A
// push result or an empty result passes through the command queue and the
// output register when the back end is idle. A pop goes through the queue,
// the length lookup and the first payload read before its first byte reaches
// the output register; it then streams one byte per cycle while the receiver
// takes them. While a pop is streaming, further pushes are taken, but a second
// pop waits until the first has read its last byte.
// When the receiver stalls, results wait in the output register and a
// four-entry command queue, after which the input stalls too.
// Reset empties the ring and the queue; no clearing pass is needed.
// ----------------------------------------------------------------------------
module packet_ring_fifo
    import prf_pkg::*;
#(
    parameter int SLOT_COUNT   = DEF_SLOT_COUNT,
    parameter int PACKET_BYTES = DEF_PACKET_BYTES
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,  // byte_value
    input  logic [1:0] s_axis_tuser,  // op
    input  logic       s_axis_tlast,
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,  // out_byte
    output logic [1:0] m_axis_tuser,  // kind
    output logic       m_axis_tlast
);

    localparam int SLOT_W = $clog2(SLOT_COUNT);
    localparam int IDX_W  = (PACKET_BYTES > 1) ? $clog2(PACKET_BYTES) : 1;
    localparam int LEN_W  = $clog2(PACKET_BYTES + 1);

    logic                    cmd_full;
    logic                    cmd_empty;
    logic                    cmd_push;
    logic                    cmd_pop;
    logic [SLOT_W+1:0]       cmd_data;
    logic [SLOT_W+1:0]       cmd_head;
    logic                    pop_done;
    logic                    pay_we;
    logic [SLOT_W+IDX_W-1:0] pay_waddr;
    logic [7:0]              pay_wdata;
    logic                    pay_re;
    logic [SLOT_W+IDX_W-1:0] pay_raddr;
    logic [7:0]              pay_rdata;
    logic                    len_we;
    logic [SLOT_W-1:0]       len_waddr;
    logic [LEN_W-1:0]        len_wdata;
    logic                    len_re;
    logic [SLOT_W-1:0]       len_raddr;
    logic [LEN_W-1:0]        len_rdata;

    prf_front #(
        .SLOT_COUNT   (SLOT_COUNT),
        .PACKET_BYTES (PACKET_BYTES)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (s_axis_tvalid),
        .item_ready (s_axis_tready),
        .op         (s_axis_tuser),
        .byte_value (s_axis_tdata),
        .byte_last  (s_axis_tlast),
        .cmd_full   (cmd_full),
        .cmd_push   (cmd_push),
        .cmd_data   (cmd_data),
        .pop_done   (pop_done),
        .pay_we     (pay_we),
        .pay_waddr  (pay_waddr),
        .pay_wdata  (pay_wdata),
        .len_we     (len_we),
        .len_waddr  (len_waddr),
        .len_wdata  (len_wdata)
    );

    prf_cmd_queue #(
        .WIDTH (SLOT_W + 2),
        .DEPTH (CMD_QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (cmd_push),
        .push_data (cmd_data),
        .full      (cmd_full),
        .pop       (cmd_pop),
        .empty     (cmd_empty),
        .head      (cmd_head)
    );

    prf_ram #(
        .WIDTH (8),
        .DEPTH (SLOT_COUNT * (2 ** IDX_W))
    ) u_payload_ram (
        .clk   (clk),
        .we    (pay_we),
        .waddr (pay_waddr),
        .wdata (pay_wdata),
        .re    (pay_re),
        .raddr (pay_raddr),
        .rdata (pay_rdata)
    );

    prf_ram #(
        .WIDTH (LEN_W),
        .DEPTH (SLOT_COUNT)
    ) u_length_ram (
        .clk   (clk),
        .we    (len_we),
        .waddr (len_waddr),
        .wdata (len_wdata),
        .re    (len_re),
        .raddr (len_raddr),
        .rdata (len_rdata)
    );

    prf_back #(
        .SLOT_COUNT   (SLOT_COUNT),
        .PACKET_BYTES (PACKET_BYTES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_empty (cmd_empty),
        .cmd_head  (cmd_head),
        .cmd_pop   (cmd_pop),
        .pop_done  (pop_done),
        .len_re    (len_re),
        .len_raddr (len_raddr),
        .len_rdata (len_rdata),
        .pay_re    (pay_re),
        .pay_raddr (pay_raddr),
        .pay_rdata (pay_rdata),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_kind  (m_axis_tuser),
        .out_byte  (m_axis_tdata),
        .out_last  (m_axis_tlast)
    );

endmodule

### rtl/prf_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Packet ring FIFO checker
// Watches the result stream of the top level and checks its framing.
// ----------------------------------------------------------------------------
module prf_checker
    import prf_pkg::*;
#(
    parameter int PACKET_BYTES = DEF_PACKET_BYTES,
    localparam int LEN_W = $clog2(PACKET_BYTES + 1)
) (
    input logic       clk,
    input logic       rst_n,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic [1:0] m_axis_tuser,
    input logic       m_axis_tlast
);

    logic             data_xfer;
    logic [LEN_W-1:0] run_cnt_reg, run_cnt_next;

    assign data_xfer = m_axis_tvalid && m_axis_tready && (m_axis_tuser == KIND_DATA);

    always_comb
    begin
        run_cnt_next = run_cnt_reg;
        if (data_xfer)
        begin
            run_cnt_next = m_axis_tlast ? '0 : run_cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_cnt_reg <= '0;
        end
        else
        begin
            run_cnt_reg <= run_cnt_next;
        end
    end

    // A stalled result holds still until it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("stalled result changed");

    // Push results and the empty result are single transactions with no data.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser != KIND_DATA |-> m_axis_tlast && m_axis_tdata == 8'd0)
    else $error("non-data result malformed");

    // A pop run ends exactly on its final packet byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        data_xfer |-> m_axis_tlast == (run_cnt_reg == LEN_W'(PACKET_BYTES - 1)))
    else $error("pop run length wrong");

    // Nothing else is interleaved into an unfinished pop run.
    assert property (@(posedge clk) disable iff (!rst_n)
        data_xfer && !m_axis_tlast |=> !m_axis_tvalid || m_axis_tuser == KIND_DATA)
    else $error("pop run interrupted");

endmodule

bind packet_ring_fifo prf_checker #(
    .PACKET_BYTES (PACKET_BYTES)
) u_prf_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

### tb/sv/packet_ring_fifo_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Packet ring FIFO testbench
// Drives byte pushes, empty pushes, pops and unused codes into the ring and
// checks every output transaction against a cycle-free model of the ring
// kept in a small scoreboard. Directed items cover the corner cases; the
// random part alternates between filling the ring to overflow and draining
// it to empty, under several sender and receiver idling patterns.
// ----------------------------------------------------------------------------
module packet_ring_fifo_test;
    import prf_pkg::*;

    localparam int SLOTS        = DEF_SLOT_COUNT;
    localparam int PKT_BYTES    = DEF_PACKET_BYTES;
    localparam int SLOT_W       = $clog2(SLOTS);
    localparam int LEN_W        = $clog2(PKT_BYTES + 1);
    localparam int IDLE_LIMIT   = 4000;
    localparam int RANDOM_ITEMS = 112;

    localparam logic [1:0] OP_UNUSED = 2'd3;

    class packet_fifo_scoreboard;
        typedef struct packed {
            logic [1:0] kind;
            logic [7:0] data;
            logic       last;
        } result_t;

        logic [SLOT_W-1:0] wr_slot;
        logic [SLOT_W-1:0] rd_slot;
        logic [7:0]        payload [SLOTS*PKT_BYTES];
        logic [LEN_W-1:0]  slot_len [SLOTS];
        logic [LEN_W-1:0]  taken;
        logic              open_pkt;
        logic              dropping;
        result_t           pending_results[$];
        int                errors;

        function new();
            wr_slot  = '0;
            rd_slot  = '0;
            taken    = '0;
            open_pkt = 1'b0;
            dropping = 1'b0;
            errors   = 0;
        endfunction

        function logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
            return (int'(s) == SLOTS - 1) ? '0 : s + 1'b1;
        endfunction

        function int occupancy();
            return (int'(wr_slot) - int'(rd_slot) + SLOTS) % SLOTS;
        endfunction

        function void add_result(input logic [1:0] k, input logic [7:0] d, input logic l);
            result_t r;
            r.kind = k;
            r.data = d;
            r.last = l;
            pending_results.push_back(r);
        endfunction

        function void start_packet();
            open_pkt = 1'b1;
            dropping = (next_slot(wr_slot) == rd_slot);
            taken    = '0;
        endfunction

        function void end_packet();
            if (dropping)
            begin
                add_result(KIND_DROPPED, 8'h00, 1'b1);
            end
            else
            begin
                slot_len[wr_slot] = taken;
                wr_slot = next_slot(wr_slot);
                add_result(KIND_ACCEPTED, 8'h00, 1'b1);
            end
            open_pkt = 1'b0;
            dropping = 1'b0;
            taken    = '0;
        endfunction

        function void accept_item(input logic [1:0] op, input logic [7:0] value,
                                  input logic last);
            int i;
            if (op == OP_PUSH_BYTE)
            begin
                if (!open_pkt)
                    start_packet();
                if (!dropping && int'(taken) < PKT_BYTES)
                begin
                    payload[int'(wr_slot)*PKT_BYTES + int'(taken)] = value;
                    taken = taken + 1'b1;
                end
                if (last)
                    end_packet();
            end
            else if (op == OP_PUSH_EMPTY)
            begin
                if (!open_pkt)
                    start_packet();
                end_packet();
            end
            else if (op == OP_POP)
            begin
                if (wr_slot == rd_slot)
                begin
                    add_result(KIND_EMPTY, 8'h00, 1'b1);
                end
                else
                begin
                    for (i = 0; i < PKT_BYTES; i++)
                        add_result(KIND_DATA,
                                   (i < int'(slot_len[rd_slot])) ?
                                       payload[int'(rd_slot)*PKT_BYTES + i] : 8'h00,
                                   i == PKT_BYTES - 1);
                    rd_slot = next_slot(rd_slot);
                end
            end
        endfunction

        function void report(input string what, input result_t want, input result_t got);
            errors++;
            if (errors <= 10)
                $display("%0t: %s: want kind=%0d byte=%02h last=%0b, got %0d %02h %0b",
                         $realtime, what, want.kind, want.data, want.last,
                         got.kind, got.data, got.last);
        endfunction

        function void compare_result(input logic [1:0] kind, input logic [7:0] data,
                                     input logic last);
            result_t got;
            result_t want;
            got.kind = kind;
            got.data = data;
            got.last = last;
            if (pending_results.size() == 0)
            begin
                want = 'x;
                report("unexpected result", want, got);
            end
            else
            begin
                want = pending_results.pop_front();
                if (got !== want)
                    report("mismatch", want, got);
            end
        endfunction

        function void count_leftover();
            if (pending_results.size() != 0)
            begin
                errors += pending_results.size();
                $display("%0d expected results never arrived", pending_results.size());
            end
        endfunction
    endclass

    logic       clk           = 1'b0;
    logic       rst_n         = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata  = 8'h00;
    logic [1:0] s_axis_tuser  = OP_PUSH_BYTE;
    logic       s_axis_tlast  = 1'b0;
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;
    logic [1:0] m_axis_tuser;
    logic       m_axis_tlast;

    packet_fifo_scoreboard sb;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int items_sent     = 0;
    int idle_cycles    = 0;

    packet_ring_fifo #(
        .SLOT_COUNT   (SLOTS),
        .PACKET_BYTES (PKT_BYTES)
    ) DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
                sb.accept_item(s_axis_tuser, s_axis_tdata, s_axis_tlast);
            if (m_axis_tvalid && m_axis_tready)
                sb.compare_result(m_axis_tuser, m_axis_tdata, m_axis_tlast);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("%0t: no transaction for %0d cycles", $realtime, IDLE_LIMIT);
                $display("[packet_ring_fifo] ERROR");
                $finish;
            end
        end
    end

    task automatic send_item(input logic [1:0] op, input logic [7:0] value, input logic last);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= value;
        s_axis_tlast  <= last;
        do
            @(posedge clk);
        while (!s_axis_tready);
        if (op != OP_UNUSED)
            items_sent++;
    endtask

    task automatic push_packet(input int nbytes, input bit end_with_empty);
        int i;
        for (i = 0; i < nbytes; i++)
        begin
            if ($urandom_range(99) < 4)
                send_item(OP_POP, 8'($urandom), 1'($urandom));
            else if ($urandom_range(99) < 2)
                send_item(OP_UNUSED, 8'($urandom), 1'($urandom));
            send_item(OP_PUSH_BYTE, 8'($urandom), (i == nbytes - 1) && !end_with_empty);
        end
        if (end_with_empty)
            send_item(OP_PUSH_EMPTY, 8'($urandom), 1'($urandom));
    endtask

    task automatic random_traffic(input int count);
        int target;
        int roll;
        int pop_pct;
        int len;
        bit filling;
        target  = items_sent + count;
        filling = 1'b1;
        while (items_sent < target)
        begin
            if (filling && sb.occupancy() == SLOTS - 1 && $urandom_range(3) == 0)
                filling = 1'b0;
            else if (!filling && sb.occupancy() == 0 && $urandom_range(1) == 0)
                filling = 1'b1;
            pop_pct = filling ? 6 : 65;
            roll    = $urandom_range(99);
            if (roll < pop_pct)
                send_item(OP_POP, 8'($urandom), 1'($urandom));
            else if (roll < pop_pct + 3)
                send_item(OP_UNUSED, 8'($urandom), 1'($urandom));
            else if (roll < pop_pct + 15)
                send_item(OP_PUSH_EMPTY, 8'($urandom), 1'($urandom));
            else
            begin
                roll = $urandom_range(99);
                if (roll < 4)
                    len = $urandom_range(PKT_BYTES + 8, PKT_BYTES + 1);
                else if (roll < 14)
                    len = $urandom_range(PKT_BYTES, 5);
                else
                    len = $urandom_range(4, 1);
                push_packet(len, $urandom_range(9) == 0);
            end
        end
    endtask

    initial
    begin
        sb = new();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_item(OP_POP, 8'h00, 1'b0);
        send_item(OP_PUSH_EMPTY, 8'h00, 1'b0);
        send_item(OP_POP, 8'hFF, 1'b1);
        send_item(OP_PUSH_BYTE, 8'hFF, 1'b0);
        send_item(OP_PUSH_BYTE, 8'h00, 1'b0);
        send_item(OP_PUSH_BYTE, 8'hA5, 1'b1);
        send_item(OP_PUSH_BYTE, 8'h3C, 1'b0);
        send_item(OP_POP, 8'h00, 1'b0);
        send_item(OP_POP, 8'h00, 1'b0);
        send_item(OP_UNUSED, 8'hFF, 1'b1);
        send_item(OP_PUSH_EMPTY, 8'h00, 1'b0);
        send_item(OP_POP, 8'h00, 1'b0);
        send_item(OP_PUSH_EMPTY, 8'hFF, 1'b1);
        send_item(OP_POP, 8'h00, 1'b0);
        send_item(OP_PUSH_BYTE, 8'h80, 1'b1);
        send_item(OP_PUSH_BYTE, 8'h01, 1'b1);
        send_item(OP_POP, 8'h00, 1'b0);
        send_item(OP_POP, 8'h00, 1'b0);
        send_item(OP_POP, 8'h00, 1'b0);

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        random_traffic(RANDOM_ITEMS / 4);
        send_idle_pct  = 76;
        recv_stall_pct = 0;
        random_traffic(RANDOM_ITEMS / 4);
        send_idle_pct  = 0;
        recv_stall_pct = 76;
        random_traffic(RANDOM_ITEMS / 4);
        send_idle_pct  = 9;
        recv_stall_pct = 9;
        random_traffic(RANDOM_ITEMS / 4);

        s_axis_tvalid <= 1'b0;
        while (sb.pending_results.size() != 0)
            @(posedge clk);
        repeat (PKT_BYTES + 8) @(posedge clk);
        sb.count_leftover();
        if (sb.errors == 0)
            $display("[packet_ring_fifo] OK");
        else
            $display("[packet_ring_fifo] ERROR");
        $finish;
    end

endmodule
